[hw/rtl/fbc_pkg.sv]
// Shared types, constants and brand decode functions for the ftyp brand classifier.
// No dependencies; used by every module of the block.
`default_nettype none

package fbc_pkg;

   localparam int COUNT_BITS = 32;
   localparam int CMP_BITS = (COUNT_BITS > 32) ? COUNT_BITS : 32;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;

   localparam logic [31:0] FTYP_CODE = 32'h66747970;
   localparam logic [31:0] MIN_BOX_SIZE = 32'd16;
   localparam logic [COUNT_BITS-1:0] MIN_FILE_LEN = COUNT_BITS'(16);
   localparam logic [COUNT_BITS-1:0] POS_SIZE_END = COUNT_BITS'(3);
   localparam logic [COUNT_BITS-1:0] POS_TYPE_END = COUNT_BITS'(7);
   localparam logic [COUNT_BITS-1:0] POS_MAJOR_END = COUNT_BITS'(11);
   localparam logic [COUNT_BITS-1:0] POS_COMPAT_END = COUNT_BITS'(19);

   typedef struct packed {
      logic valid_ftyp;
      logic still_image;
      logic image_sequence;
   } result_type;

   function automatic logic is_still_brand(input logic [31:0] w);
      logic hit;
      hit = 1'b0;
      unique case (w) inside
         32'h61766369, 32'h61766966, 32'h68656963, 32'h68656966,
         32'h6865696d, 32'h68656973, 32'h68656978, 32'h68656a32,
         32'h6a326b69, 32'h6a706567, 32'h6d696631, 32'h6d696632,
         32'h76766963: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic logic is_sequence_brand(input logic [31:0] w);
      logic hit;
      hit = 1'b0;
      unique case (w) inside
         32'h61766373, 32'h61766973, 32'h68657663, 32'h6865766d,
         32'h68657673, 32'h68657678, 32'h6a326973, 32'h6a706773,
         32'h6d736631, 32'h76766973: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/fbc_front.sv]
// Front part: accepts file bytes, tracks box header state, matches brands
// and forms one result item per file. Depends on fbc_pkg.
`default_nettype none

module fbc_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [7:0]          data_byte,
   input  wire logic                end_of_file,
   output fbc_pkg::result_type      result,
   output logic                     result_push
);

   logic [fbc_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [31:0]                    word_ff, word_in;
   logic [31:0]                    box_ff, box_in;
   logic                           type_ff, type_in;
   logic                           still_ff, still_in;
   logic                           seq_ff, seq_in;
   logic                           exact;
   logic                           classify;
   logic                           compat_in_box;
   logic                           valid;

   always_comb begin
      word_in = {word_ff[23:0], data_byte};
      exact = (count_ff != fbc_pkg::COUNT_MAX);
      compat_in_box = (fbc_pkg::CMP_BITS'(count_ff) < fbc_pkg::CMP_BITS'(box_ff));
      box_in = box_ff;
      type_in = type_ff;
      classify = 1'b0;
      count_in = count_ff;
      if (exact) begin
         if (count_ff == fbc_pkg::POS_SIZE_END) begin
            box_in = word_in;
         end else if (count_ff == fbc_pkg::POS_TYPE_END) begin
            type_in = (word_in == fbc_pkg::FTYP_CODE);
         end else if (count_ff == fbc_pkg::POS_MAJOR_END) begin
            classify = 1'b1;
         end else if (count_ff >= fbc_pkg::POS_COMPAT_END && count_ff[1:0] == 2'b11
                      && compat_in_box) begin
            classify = 1'b1;
         end
         count_in = count_ff + 1'b1;
      end
      still_in = still_ff | (classify & fbc_pkg::is_still_brand(word_in));
      seq_in = seq_ff | (classify & fbc_pkg::is_sequence_brand(word_in));
      valid = (count_in >= fbc_pkg::MIN_FILE_LEN) && type_in
              && (box_in >= fbc_pkg::MIN_BOX_SIZE)
              && (fbc_pkg::CMP_BITS'(box_in) <= fbc_pkg::CMP_BITS'(count_in));
      result.valid_ftyp = valid;
      result.still_image = valid & still_in;
      result.image_sequence = valid & seq_in;
      result_push = accept & end_of_file;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && end_of_file)) begin
         count_ff <= '0;
         word_ff <= '0;
         box_ff <= '0;
         type_ff <= 1'b0;
         still_ff <= 1'b0;
         seq_ff <= 1'b0;
      end else if (accept) begin
         count_ff <= count_in;
         word_ff <= word_in;
         box_ff <= box_in;
         type_ff <= type_in;
         still_ff <= still_in;
         seq_ff <= seq_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/fbc_queue.sv]
// Back part: short result queue that holds finished items until popped.
// Depends on fbc_pkg.
`default_nettype none

module fbc_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire fbc_pkg::result_type push_data,
   output logic                     full,
   output logic                     empty,
   input  wire logic                pop,
   output fbc_pkg::result_type      pop_data
);

   fbc_pkg::result_type                entry_ff [fbc_pkg::QUEUE_DEPTH];
   logic [fbc_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [fbc_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                               do_push, do_pop;

   always_comb begin
      full = (count_ff == fbc_pkg::QUEUE_CNT_BITS'(fbc_pkg::QUEUE_DEPTH));
      empty = (count_ff == '0);
      do_push = push & ~full;
      do_pop = pop & ~empty;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
      pop_data = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/ftyp_brand_classifier_core.sv]
// Top level of the ftyp brand classifier: front classifier and result queue.
// Depends on fbc_pkg, fbc_front and fbc_queue.
//
// Usage: stream a file one byte per item on req_data_byte, with
// req_end_of_file set on its final byte. A byte is taken at a clock edge
// where push is high and full is low. The block checks the box size in
// bytes 0..3, the "ftyp" tag in bytes 4..7, and matches the major brand
// and each whole compatible brand inside the box against still-image and
// image-sequence brand lists.
// One result item per file appears in the cycle after its final byte is
// taken; it sits on the rsp_ ports while empty is low and leaves at an
// edge where pop is high. Bytes are taken every cycle (one item per
// cycle) as long as the two-entry result queue has room; once two results
// wait unpopped, full rises and every byte is held off until the receiver
// pops one.
// Reset clears the byte counter, the header state, the brand flags and
// the result queue; the block is ready as soon as reset drops.
`default_nettype none

module ftyp_brand_classifier_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_end_of_file,
   output logic            empty,
   input  wire logic       pop,
   output logic            rsp_valid_ftyp,
   output logic            rsp_still_image,
   output logic            rsp_image_sequence
);

   fbc_pkg::result_type front_result;
   fbc_pkg::result_type queue_head;
   logic                front_push;
   logic                accept;

   assign accept = push & ~full;

   fbc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .end_of_file (req_end_of_file),
      .result      (front_result),
      .result_push (front_push)
   );

   fbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_result),
      .full      (full),
      .empty     (empty),
      .pop       (pop),
      .pop_data  (queue_head)
   );

   assign rsp_valid_ftyp = queue_head.valid_ftyp;
   assign rsp_still_image = queue_head.still_image;
   assign rsp_image_sequence = queue_head.image_sequence;

endmodule

`default_nettype wire
